>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the trainer block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled in reset
`define NBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset
`define NBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/nbt_pkg.sv
// Types, constants and helpers of the naive Bayes trainer
`timescale 1ns / 1ps
package nbt_pkg;
  localparam int FEATURE_COUNT = 1024;
  localparam int FEAT_BITS     = $clog2(FEATURE_COUNT);
  localparam int WORD_BITS     = 64;
  localparam int BIT_SEL_BITS  = $clog2(WORD_BITS);
  localparam int WORD_SLOTS    = FEATURE_COUNT / WORD_BITS;
  localparam int WIDX_BITS     = $clog2(WORD_SLOTS);
  localparam int COUNT_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int Q_BITS        = FRAC_BITS + 1;
  localparam int DIV_BITS      = COUNT_BITS + 1;
  localparam int PCT_BITS      = 7;
  localparam int PCT_MAX       = 100;
  localparam int PCT_RESET     = 25;
  localparam int SEEN_BITS     = FEAT_BITS + 1;

  localparam logic [Q_BITS-1:0] ONE_Q = Q_BITS'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [1:0] LBL_CLEAN    = 2'd0;
  localparam logic [1:0] LBL_INFECTED = 2'd1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLEAR  = 6'b000010,
    S_COMMIT = 6'b000100,
    S_QREAD  = 6'b001000,
    S_DSTART = 6'b010000,
    S_DWAIT  = 6'b100000
  } state_t;

  // Divider request and response
  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] num;
    logic [DIV_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [Q_BITS-1:0] quot;
  } div_rsp_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
  endfunction
endpackage

>>> rtl/core/nbt_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module nbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/nbt_div.sv
// Bit-serial fractional divider with clamp to 1.0
`timescale 1ns / 1ps
module nbt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  nbt_pkg::div_req_t req,
  output nbt_pkg::div_rsp_t rsp
);
  import nbt_pkg::*;

  localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

  logic [DIV_BITS:0]   rem_r,  rem_nxt;
  logic [DIV_BITS-1:0] den_r,  den_nxt;
  logic [FRAC_BITS-1:0] q_r,   q_nxt;
  logic [CNT_BITS-1:0] cnt_r,  cnt_nxt;
  logic                act_r,  act_nxt;
  logic                done_r, done_nxt;
  logic [Q_BITS-1:0]   quot_r, quot_nxt;
  logic [DIV_BITS:0]   rem_sh;
  logic                ge;

  assign rem_sh = {rem_r[DIV_BITS-1:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, den_r};

  // Resolve trivial cases at once, else shift-subtract one bit a cycle
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    act_nxt  = act_r;
    done_nxt = 1'b0;
    quot_nxt = quot_r;
    if (req.start) begin
      if (req.den == '0) begin
        quot_nxt = '0;
        done_nxt = 1'b1;
      end else if (req.num >= req.den) begin
        quot_nxt = ONE_Q;
        done_nxt = 1'b1;
      end else begin
        rem_nxt = {1'b0, req.num};
        den_nxt = req.den;
        q_nxt   = '0;
        cnt_nxt = CNT_BITS'(FRAC_BITS);
        act_nxt = 1'b1;
      end
    end else if (act_r) begin
      rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;
      q_nxt   = {q_r[FRAC_BITS-2:0], ge};
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        act_nxt  = 1'b0;
        done_nxt = 1'b1;
        quot_nxt = {1'b0, q_r[FRAC_BITS-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
endmodule

>>> rtl/core/naive_bayes_trainer.sv
// Top level of the naive Bayes trainer: sequencer, counters and totals
//
// Takes one request when start is high and busy is low. A record word without
// last_word is stored in the word buffer and leaves busy low. A last word
// commits the record by a sweep over all 1024 features whatever the flags,
// with one counter read-modify-write per set flag of a clean or infected
// record. A clear request, and reset, sweep both counter memories; busy
// stays high during that sweep. A query reads the feature's counters, then runs
// four divisions (two when the feature is forced to 1.0) on one shared serial
// divider, which skips its bit-serial loop when the divisor is zero or the
// quotient reaches 1.0. The result shows for one cycle with out_valid as busy
// drops and cannot be held off. cfg_we writes ignore_percent at any time and
// is meant to be used while no request is in work.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module naive_bayes_trainer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_command,
  input  logic [1:0]                      in_label,
  input  logic [nbt_pkg::WIDX_BITS-1:0]   in_word_index,
  input  logic [nbt_pkg::WORD_BITS-1:0]   in_feature_bits,
  input  logic                            in_last_word,
  input  logic [nbt_pkg::FEAT_BITS-1:0]   in_feature_index,
  input  logic                            cfg_we,
  input  logic [nbt_pkg::PCT_BITS-1:0]    cfg_wdata,
  output logic                            out_valid,
  output logic [nbt_pkg::Q_BITS-1:0]      out_prob_clean,
  output logic [nbt_pkg::Q_BITS-1:0]      out_prob_infected,
  output logic [nbt_pkg::Q_BITS-1:0]      out_prior_clean,
  output logic [nbt_pkg::Q_BITS-1:0]      out_prior_infected,
  output logic                            out_feature_kept
);
  import nbt_pkg::*;

  localparam int SWEEP_BITS = FEAT_BITS + 1;
  localparam int PROD_BITS  = COUNT_BITS + PCT_BITS;
  localparam int SUM_BITS   = COUNT_BITS + 2;
  localparam int X100_BITS  = SUM_BITS + 7;

  state_t                state_r, state_nxt;
  logic [SWEEP_BITS-1:0] sweep_r, sweep_nxt;
  logic [1:0]            label_r, label_nxt;
  logic [COUNT_BITS-1:0] rec_tot_r, rec_tot_nxt;
  logic [COUNT_BITS-1:0] cln_tot_r, cln_tot_nxt;
  logic [COUNT_BITS-1:0] inf_tot_r, inf_tot_nxt;
  logic [SEEN_BITS-1:0]  seen_r, seen_nxt;
  logic [PCT_BITS-1:0]   pct_r;
  logic [PROD_BITS-1:0]  prod_r;
  logic [WORD_BITS-1:0]  pend_r [WORD_SLOTS];

  // Commit pipeline stage
  logic                  p_vld_r, p_bit_r;
  logic [FEAT_BITS-1:0]  p_addr_r;

  // Query operands and results
  logic [DIV_BITS-1:0]   numc_r, numc_nxt, numi_r, numi_nxt;
  logic                  kept_r, kept_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [Q_BITS-1:0]     pc_r, pc_nxt, pi_r, pi_nxt, prc_r, prc_nxt, pri_r, pri_nxt;
  logic                  ov_r, ov_nxt;

  // Memory ports
  logic [FEAT_BITS-1:0]  raddr, waddr;
  logic                  we_c, we_i;
  logic [COUNT_BITS-1:0] rd_c, rd_i, wd_c, wd_i;

  div_req_t dreq;
  div_rsp_t drsp;

  logic                  accept, count_on, fresh;
  logic [PCT_BITS-1:0]   pct_eff;
  logic [SUM_BITS-1:0]   sum1;
  logic [X100_BITS-1:0]  x100;
  logic                  q_kept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  nbt_ram #(.WIDTH(COUNT_BITS), .DEPTH(FEATURE_COUNT)) u_ram_clean (
    .clk(clk), .we(we_c), .waddr(waddr), .wdata(wd_c), .raddr(raddr), .rdata(rd_c)
  );
  nbt_ram #(.WIDTH(COUNT_BITS), .DEPTH(FEATURE_COUNT)) u_ram_infected (
    .clk(clk), .we(we_i), .waddr(waddr), .wdata(wd_i), .raddr(raddr), .rdata(rd_i)
  );
  nbt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Read query feature when idle, sweep feature while committing
  assign raddr = (state_r == S_COMMIT) ? sweep_r[FEAT_BITS-1:0] : in_feature_index;

  // Counter update of the commit stage, or zero fill during a clear sweep
  assign count_on = p_vld_r && p_bit_r;
  assign fresh    = (rd_c == '0) && (rd_i == '0);
  assign waddr    = (state_r == S_CLEAR) ? sweep_r[FEAT_BITS-1:0] : p_addr_r;
  assign we_c     = (state_r == S_CLEAR) || (count_on && label_r == LBL_CLEAN);
  assign we_i     = (state_r == S_CLEAR) || (count_on && label_r == LBL_INFECTED);
  assign wd_c     = (state_r == S_CLEAR) ? '0 : sat_inc(rd_c);
  assign wd_i     = (state_r == S_CLEAR) ? '0 : sat_inc(rd_i);

  // Ignore check: sum < floor(prod/100) exactly when (sum+1)*100 <= prod
  assign pct_eff = (pct_r > PCT_BITS'(PCT_MAX)) ? PCT_BITS'(PCT_MAX) : pct_r;
  assign sum1    = SUM_BITS'(rd_c) + SUM_BITS'(rd_i) + SUM_BITS'(1);
  assign x100    = (X100_BITS'(sum1) << 6) + (X100_BITS'(sum1) << 5)
                 + (X100_BITS'(sum1) << 2);
  assign q_kept  = (sum1 != SUM_BITS'(1)) && (x100 <= X100_BITS'(prod_r));

  // Divider operand select per step
  always_comb begin
    dreq.start = (state_r == S_DSTART);
    unique case (op_r)
      2'd0: begin
        dreq.num = numc_r;
        dreq.den = DIV_BITS'(cln_tot_r) + DIV_BITS'(seen_r);
      end
      2'd1: begin
        dreq.num = numi_r;
        dreq.den = DIV_BITS'(inf_tot_r) + DIV_BITS'(seen_r);
      end
      2'd2: begin
        dreq.num = DIV_BITS'(cln_tot_r);
        dreq.den = DIV_BITS'(rec_tot_r);
      end
      default: begin
        dreq.num = DIV_BITS'(inf_tot_r);
        dreq.den = DIV_BITS'(rec_tot_r);
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    sweep_nxt   = sweep_r;
    label_nxt   = label_r;
    rec_tot_nxt = rec_tot_r;
    cln_tot_nxt = cln_tot_r;
    inf_tot_nxt = inf_tot_r;
    seen_nxt    = seen_r;
    numc_nxt    = numc_r;
    numi_nxt    = numi_r;
    kept_nxt    = kept_r;
    op_nxt      = op_r;
    pc_nxt      = pc_r;
    pi_nxt      = pi_r;
    prc_nxt     = prc_r;
    pri_nxt     = pri_r;
    ov_nxt      = 1'b0;
    // count a newly seen feature from the commit stage
    if (count_on && (label_r == LBL_CLEAN || label_r == LBL_INFECTED) && fresh) begin
      seen_nxt = seen_r + SEEN_BITS'(1);
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_command))
            CMD_RECORD: begin
              if (in_last_word) begin
                rec_tot_nxt = sat_inc(rec_tot_r);
                if (in_label == LBL_CLEAN) cln_tot_nxt = sat_inc(cln_tot_r);
                if (in_label == LBL_INFECTED) inf_tot_nxt = sat_inc(inf_tot_r);
                label_nxt = in_label;
                sweep_nxt = '0;
                state_nxt = S_COMMIT;
              end
            end
            CMD_QUERY: state_nxt = S_QREAD;
            CMD_CLEAR: begin
              rec_tot_nxt = '0;
              cln_tot_nxt = '0;
              inf_tot_nxt = '0;
              seen_nxt    = '0;
              sweep_nxt   = '0;
              state_nxt   = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        sweep_nxt = sweep_r + SWEEP_BITS'(1);
        if (sweep_r[FEAT_BITS-1:0] == {FEAT_BITS{1'b1}}) state_nxt = S_IDLE;
      end
      S_COMMIT: begin
        if (sweep_r[FEAT_BITS]) state_nxt = S_IDLE;
        else sweep_nxt = sweep_r + SWEEP_BITS'(1);
      end
      S_QREAD: begin
        numc_nxt  = DIV_BITS'(rd_c) + DIV_BITS'(1);
        numi_nxt  = DIV_BITS'(rd_i) + DIV_BITS'(1);
        kept_nxt  = q_kept;
        pc_nxt    = ONE_Q;
        pi_nxt    = ONE_Q;
        op_nxt    = q_kept ? 2'd0 : 2'd2;
        state_nxt = S_DSTART;
      end
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (drsp.done) begin
          unique case (op_r)
            2'd0: pc_nxt = drsp.quot;
            2'd1: pi_nxt = drsp.quot;
            2'd2: prc_nxt = drsp.quot;
            default: pri_nxt = drsp.quot;
          endcase
          if (op_r == 2'd3) begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            op_nxt    = op_r + 2'd1;
            state_nxt = S_DSTART;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      sweep_r   <= '0;
      rec_tot_r <= '0;
      cln_tot_r <= '0;
      inf_tot_r <= '0;
      seen_r    <= '0;
      pct_r     <= PCT_BITS'(PCT_RESET);
      p_vld_r   <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sweep_r   <= sweep_nxt;
      rec_tot_r <= rec_tot_nxt;
      cln_tot_r <= cln_tot_nxt;
      inf_tot_r <= inf_tot_nxt;
      seen_r    <= seen_nxt;
      if (cfg_we) pct_r <= cfg_wdata;
      p_vld_r   <= (state_r == S_COMMIT) && !sweep_r[FEAT_BITS];
      ov_r      <= ov_nxt;
    end
    label_r  <= label_nxt;
    numc_r   <= numc_nxt;
    numi_r   <= numi_nxt;
    kept_r   <= kept_nxt;
    op_r     <= op_nxt;
    pc_r     <= pc_nxt;
    pi_r     <= pi_nxt;
    prc_r    <= prc_nxt;
    pri_r    <= pri_nxt;
    prod_r   <= PROD_BITS'(rec_tot_r) * PROD_BITS'(pct_eff);
    p_addr_r <= sweep_r[FEAT_BITS-1:0];
    p_bit_r  <= pend_r[sweep_r[FEAT_BITS-1:BIT_SEL_BITS]][sweep_r[BIT_SEL_BITS-1:0]];
  end

  // Word buffer: store incoming words, drop each word once its features are swept
  always_ff @(posedge clk) begin
    if (accept && cmd_t'(in_command) == CMD_RECORD) begin
      pend_r[in_word_index] <= in_feature_bits;
    end else if (state_r == S_COMMIT && !sweep_r[FEAT_BITS]
                 && sweep_r[BIT_SEL_BITS-1:0] == {BIT_SEL_BITS{1'b1}}) begin
      pend_r[sweep_r[FEAT_BITS-1:BIT_SEL_BITS]] <= '0;
    end
  end

  assign out_valid          = ov_r;
  assign out_prob_clean     = pc_r;
  assign out_prob_infected  = pi_r;
  assign out_prior_clean    = prc_r;
  assign out_prior_infected = pri_r;
  assign out_feature_kept   = kept_r;

  `NBT_ASSERT_IMP(a_result_when_idle, clk, rst_n, ov_r, state_r == S_IDLE)
  `NBT_ASSERT_IMP(a_forced_one, clk, rst_n, ov_r && !kept_r, pc_r == ONE_Q && pi_r == ONE_Q)
  `NBT_ASSERT_NXT(a_query_reads, clk, rst_n, accept && cmd_t'(in_command) == CMD_QUERY, state_r == S_QREAD)
  `NBT_ASSERT_IMP(a_stage_in_commit, clk, rst_n, p_vld_r, state_r == S_COMMIT)
endmodule

>>> verif/naive_bayes_trainer_test.sv
// Self-checking testbench of the naive Bayes trainer: directed and random requests
`timescale 1ns / 1ps
module naive_bayes_trainer_test;
  import nbt_pkg::*;

  localparam logic [1:0] LBL_UNLABELED = 2'd2;
  localparam logic [1:0] LBL_SPARE     = 2'd3;
  localparam int DRAIN_CYCLES = 1200;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic [Q_BITS-1:0] prob_clean;
    logic [Q_BITS-1:0] prob_infected;
    logic [Q_BITS-1:0] prior_clean;
    logic [Q_BITS-1:0] prior_infected;
    logic              kept;
  } estimate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_command = CMD_NONE;
  logic [1:0] in_label = '0;
  logic [WIDX_BITS-1:0] in_word_index = '0;
  logic [WORD_BITS-1:0] in_feature_bits = '0;
  logic in_last_word = 1'b0;
  logic [FEAT_BITS-1:0] in_feature_index = '0;
  logic cfg_we = 1'b0;
  logic [PCT_BITS-1:0] cfg_wdata = '0;
  logic out_valid;
  logic [Q_BITS-1:0] out_prob_clean, out_prob_infected, out_prior_clean, out_prior_infected;
  logic out_feature_kept;

  naive_bayes_trainer dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_label(in_label), .in_word_index(in_word_index),
    .in_feature_bits(in_feature_bits), .in_last_word(in_last_word),
    .in_feature_index(in_feature_index), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_prob_clean(out_prob_clean),
    .out_prob_infected(out_prob_infected), .out_prior_clean(out_prior_clean),
    .out_prior_infected(out_prior_infected), .out_feature_kept(out_feature_kept)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [COUNT_BITS-1:0] clean_cnt [FEATURE_COUNT];
  logic [COUNT_BITS-1:0] infected_cnt [FEATURE_COUNT];
  logic [COUNT_BITS-1:0] clean_sum, infected_sum, record_sum;
  logic [SEEN_BITS-1:0] seen_sum;
  logic [WORD_BITS-1:0] word_buf [WORD_SLOTS];
  logic [PCT_BITS-1:0] pct_reg;

  estimate_t estimates_due[$];
  int errors = 0;
  int queries_checked = 0;
  int records_done = 0;
  int clears_done = 0;
  int items_sent = 0;
  int idle_pct = 38;
  longint cycles = 0;

  function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [Q_BITS-1:0] q_ratio(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    if (den == 0) return '0;
    q = (num << FRAC_BITS) / den;
    return (q > 64'(ONE_Q)) ? ONE_Q : q[Q_BITS-1:0];
  endfunction

  task automatic zero_counts();
    for (int f = 0; f < FEATURE_COUNT; f++) begin
      clean_cnt[f] = '0;
      infected_cnt[f] = '0;
    end
    clean_sum = '0;
    infected_sum = '0;
    record_sum = '0;
    seen_sum = '0;
  endtask

  task automatic commit_model(logic [1:0] lbl);
    int f;
    logic fresh;
    record_sum = bump(record_sum);
    if (lbl == LBL_CLEAN) clean_sum = bump(clean_sum);
    else if (lbl == LBL_INFECTED) infected_sum = bump(infected_sum);
    for (int w = 0; w < WORD_SLOTS; w++) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        f = w * WORD_BITS + b;
        if (word_buf[w][b] && lbl <= LBL_INFECTED) begin
          fresh = clean_cnt[f] == 0 && infected_cnt[f] == 0;
          if (lbl == LBL_CLEAN) clean_cnt[f] = bump(clean_cnt[f]);
          else infected_cnt[f] = bump(infected_cnt[f]);
          if (fresh) seen_sum++;
        end
      end
      word_buf[w] = '0;
    end
    records_done++;
  endtask

  // Work out the answer to one query from the current counts
  function automatic estimate_t query_model(logic [FEAT_BITS-1:0] idx);
    estimate_t e;
    logic [63:0] c, i, limit;
    int pct;
    pct = (pct_reg > PCT_MAX) ? PCT_MAX : pct_reg;
    limit = (64'(record_sum) * pct) / PCT_MAX;
    c = clean_cnt[idx];
    i = infected_cnt[idx];
    e.prob_clean = ONE_Q;
    e.prob_infected = ONE_Q;
    e.kept = 1'b0;
    if ((c != 0 || i != 0) && c + i < limit) begin
      e.prob_clean = q_ratio(c + 1, 64'(clean_sum) + seen_sum);
      e.prob_infected = q_ratio(i + 1, 64'(infected_sum) + seen_sum);
      e.kept = 1'b1;
    end
    e.prior_clean = q_ratio(clean_sum, record_sum);
    e.prior_infected = q_ratio(infected_sum, record_sum);
    return e;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Send one request and hold it until accepted, then predict its effect
  task automatic send(logic [1:0] cmd, logic [1:0] lbl, logic [WIDX_BITS-1:0] widx,
                      logic [WORD_BITS-1:0] bits, logic last, logic [FEAT_BITS-1:0] fidx);
    @(negedge clk);
    in_command = cmd;
    in_label = lbl;
    in_word_index = widx;
    in_feature_bits = bits;
    in_last_word = last;
    in_feature_index = fidx;
    start = 1'b1;
    do @(posedge clk); while (busy);
    if (cmd != CMD_NONE) items_sent++;
    case (cmd)
      CMD_RECORD: begin
        word_buf[widx] = bits;
        if (last) commit_model(lbl);
      end
      CMD_QUERY: estimates_due.push_back(query_model(fidx));
      CMD_CLEAR: begin
        zero_counts();
        clears_done++;
      end
      default: ;
    endcase
  endtask

  // Drop start for a random gap
  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(6)) @(negedge clk);
    end
  endtask

  task automatic write_pct(logic [PCT_BITS-1:0] v);
    @(negedge clk);
    start = 1'b0;
    wait (estimates_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    pct_reg = v;
  endtask

  function automatic logic [WORD_BITS-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WORD_BITS-1:0] sparse_word();
    logic [WORD_BITS-1:0] w;
    w = '0;
    repeat ($urandom_range(3)) w[$urandom_range(WORD_BITS - 1)] = 1'b1;
    return w;
  endfunction

  // Check each result against the oldest expected estimate
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (estimates_due.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        estimate_t e;
        e = estimates_due.pop_front();
        queries_checked++;
        if (out_prob_clean !== e.prob_clean) report("prob_clean", out_prob_clean, e.prob_clean);
        if (out_prob_infected !== e.prob_infected)
          report("prob_infected", out_prob_infected, e.prob_infected);
        if (out_prior_clean !== e.prior_clean)
          report("prior_clean", out_prior_clean, e.prior_clean);
        if (out_prior_infected !== e.prior_infected)
          report("prior_infected", out_prior_infected, e.prior_infected);
        if (out_feature_kept !== e.kept) report("feature_kept", out_feature_kept, e.kept);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Empty model: priors zero, features forced, then one full record with the flags of every odd word set
  task automatic test_empty_and_full_record();
    send(CMD_QUERY, LBL_CLEAN, 0, 0, 0, 0);
    send(CMD_QUERY, LBL_CLEAN, 0, 0, 0, FEAT_BITS'(FEATURE_COUNT - 1));
    for (int w = 0; w < WORD_SLOTS; w++)
      send(CMD_RECORD, LBL_CLEAN, w, (w % 2) ? '1 : '0, w == WORD_SLOTS - 1, 0);
    send(CMD_QUERY, LBL_CLEAN, 0, 0, 0, 64);
    send(CMD_QUERY, LBL_CLEAN, 0, 0, 0, FEAT_BITS'(FEATURE_COUNT - 1));
  endtask

  // Every label, including the spare code, and an ignored command
  task automatic test_labels();
    send(CMD_RECORD, LBL_INFECTED, 0, 64'h1, 1, 0);
    send(CMD_RECORD, LBL_UNLABELED, 0, 64'h3, 1, 0);
    send(CMD_RECORD, LBL_SPARE, 3, 64'h8000_0000_0000_0000, 1, 0);
    send(CMD_NONE, LBL_CLEAN, 0, '1, 1, 5);
    send(CMD_RECORD, LBL_CLEAN, 15, 64'h1, 1, 0);
    send(CMD_QUERY, LBL_CLEAN, 0, 0, 0, 0);
    send(CMD_QUERY, LBL_CLEAN, 0, 0, 0, 1);
    send(CMD_QUERY, LBL_CLEAN, 0, 0, 0, 960);
  endtask

  // Clear wipes counts but keeps the word buffer
  task automatic test_clear();
    send(CMD_RECORD, LBL_INFECTED, 2, 64'hF0, 0, 0);
    send(CMD_CLEAR, LBL_CLEAN, 0, 0, 0, 0);
    send(CMD_QUERY, LBL_CLEAN, 0, 0, 0, 132);
    send(CMD_RECORD, LBL_INFECTED, 0, 64'h0, 1, 0);
    send(CMD_QUERY, LBL_CLEAN, 0, 0, 0, 132);
  endtask

  // Random records, queries and noise under one threshold setting
  task automatic test_random(int count, logic [PCT_BITS-1:0] pct);
    int words, roll, sent_here;
    logic [1:0] lbl;
    write_pct(pct);
    sent_here = 0;
    while (sent_here < count) begin
      idle_pct = (sent_here > count / 3 && sent_here < count / 2) ? 0 : 38;
      roll = $urandom_range(99);
      if (roll < 50) begin
        words = $urandom_range(1, 3);
        lbl = $urandom_range(3);
        for (int k = 0; k < words; k++) begin
          send(CMD_RECORD, lbl, $urandom_range(WORD_SLOTS - 1),
               ($urandom_range(3) == 0) ? rand_word() : sparse_word(), k == words - 1, 0);
          maybe_idle();
        end
        sent_here += words;
      end else if (roll < 94) begin
        send(CMD_QUERY, $urandom_range(3), $urandom_range(WORD_SLOTS - 1), rand_word(),
             $urandom_range(1), $urandom_range(FEATURE_COUNT - 1));
        sent_here++;
      end else if (roll < 96) begin
        send(CMD_CLEAR, $urandom_range(3), 0, rand_word(), $urandom_range(1), 0);
        sent_here++;
      end else if (roll < 98) begin
        send(CMD_NONE, $urandom_range(3), $urandom_range(WORD_SLOTS - 1), rand_word(),
             $urandom_range(1), $urandom_range(FEATURE_COUNT - 1));
      end else begin
        send(CMD_RECORD, $urandom_range(3), $urandom_range(WORD_SLOTS - 1), rand_word(), 0, 0);
        sent_here++;
      end
      maybe_idle();
    end
  endtask

  initial begin
    zero_counts();
    for (int w = 0; w < WORD_SLOTS; w++) word_buf[w] = '0;
    pct_reg = PCT_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_and_full_record();
    test_labels();
    write_pct(PCT_MAX);
    test_labels();
    test_clear();
    test_random(300, PCT_MAX);
    test_random(250, 0);
    test_random(300, 7'h7F);
    test_random(350, $urandom_range(1, 99));

    @(negedge clk);
    start = 1'b0;
    wait (estimates_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests: %0d records committed, %0d queries checked, %0d clears",
             items_sent, records_done, queries_checked, clears_done);
    $display("thresholds swept over 25, 100, 0, 127 and one random percent");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
